FILE: sv/tick_timer_compare_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// Tick timer compare scheduler: assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TICK_TIMER_COMPARE_SCHEDULER_CORE_MACROS_SVH
`define TICK_TIMER_COMPARE_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tick timer scheduler check failed");
// next-cycle implication
`define TTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tick timer scheduler check failed");
`else
`define TTS_ASSERT_IMP(lbl, ante, cons)
`define TTS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/tts_pkg.sv
// ----------------------------------------------------------------------------
// Tick timer compare scheduler package
// Shared constants, register and request codes, divider control types.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int COUNTER_BITS_DEF = 64;

  localparam int CPT_W = 31;
  localparam int DVD_W = 64;
  localparam int CNT_W = 7;

  localparam logic [CNT_W-1:0] DIV_STEPS_WIDE   = 7'd64;
  localparam logic [CNT_W-1:0] DIV_STEPS_NARROW = 7'd32;

  localparam logic [31:0] MAX_CYC = 32'h7FFF_FFFF;

  // configuration register indexes
  localparam logic [7:0] REG_CPT       = 8'd0;
  localparam logic [7:0] REG_TICKLESS  = 8'd1;
  localparam logic [7:0] REG_MIN_DELAY = 8'd2;

  localparam logic [CPT_W-1:0] CPT_RESET       = 31'd10000;
  localparam logic             TICKLESS_RESET  = 1'b1;
  localparam logic [CPT_W-1:0] MIN_DELAY_RESET = 31'd1000;

  // request kinds
  localparam logic [1:0] MODE_IRQ     = 2'd0;
  localparam logic [1:0] MODE_TIMEOUT = 2'd1;
  localparam logic [1:0] MODE_ELAPSED = 2'd2;

  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: sv/tts_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle: 64 steps for a wide dividend, 32 for a narrow one.
// ----------------------------------------------------------------------------
module tts_div
  import tts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [DVD_W-1:0] dividend,
  input  logic [CPT_W-1:0] divisor,
  output div_sts_t         sts,
  output logic [DVD_W-1:0] quotient,
  output logic [CPT_W-1:0] remainder
);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [CPT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CPT_W:0]   trial;
  logic [CPT_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      // narrow dividends sit in the upper half so the shift order is the same
      dvd_nxt  = req.wide ? dividend : {dividend[31:0], 32'd0};
      rem_nxt  = '0;
      cnt_nxt  = req.wide ? DIV_STEPS_WIDE : DIV_STEPS_NARROW;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[CPT_W-1:0] : trial[CPT_W-1:0];
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

FILE: sv/tick_timer_compare_scheduler_core.sv
// ----------------------------------------------------------------------------
// Tick timer compare scheduler core
// Converts free-running counter values into kernel ticks and compare values.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake. tuser gives the kind (interrupt,
//           timeout, elapsed query) and the idle flag; tdata carries the
//           counter value and the requested timeout in ticks.
//   out_* : exactly one result per request, in order. tuser flags a compare
//           write; tdata carries compare value, announced and elapsed ticks.
//   cfg_* : register writes (cycles per tick, tickless mode, minimum delay),
//           always ready; write them only while no request is in flight.
// Tickless interrupts, tickless elapsed queries and non-idle tickless timeouts
// use the shared bit-serial divider, one quotient bit a cycle; such a timeout
// takes two 32-step divides plus clamp, multiply, offset, rounding, delay check.
// Periodic interrupts and requests that program nothing do not use the divider.
// in_tready is high only between requests; one request is worked at a time.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, a second result holds the core until then.
// Reset (synchronous, rst_n low) restores the register defaults and clears
// the last announced counter value.
// ----------------------------------------------------------------------------
`include "tick_timer_compare_scheduler_core_macros.svh"

module tick_timer_compare_scheduler_core
  import tts_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // request channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // [63:0] counter_now, [95:64] timeout_ticks
  input  logic [2:0]   in_tuser,   // [1:0] mode, [2] idle
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] compare_value, [95:64] announced_ticks,
                                   // [127:96] elapsed_ticks
  output logic [0:0]   out_tuser,  // [0] compare_write
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_PNXT  = 4'd2;
  localparam logic [3:0] S_TMAX  = 4'd3;
  localparam logic [3:0] S_TCLMP = 4'd4;
  localparam logic [3:0] S_TMUL  = 4'd5;
  localparam logic [3:0] S_TADJ  = 4'd6;
  localparam logic [3:0] S_TDIVS = 4'd7;
  localparam logic [3:0] S_TDIV  = 4'd8;
  localparam logic [3:0] S_TSM   = 4'd9;
  localparam logic [3:0] S_TCMP  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // configuration
  logic [CPT_W-1:0] cpt_r;
  logic             tickless_r;
  logic [CPT_W-1:0] min_delay_r;
  logic [CPT_W-1:0] cpt_eff;

  // sequencer and working registers
  logic [3:0]              state_r;
  logic [COUNTER_BITS-1:0] last_r;
  logic [COUNTER_BITS-1:0] now_r;
  logic [1:0]              mode_r;
  logic [31:0]             t_r;
  logic [CPT_W-1:0]        maxt_r;
  logic [CPT_W-1:0]        tcl_r;
  logic [31:0]             cyc_r;

  // pending result
  logic                    res_wr_r;
  logic [COUNTER_BITS-1:0] res_cmp_r;
  logic [31:0]             res_ann_r;
  logic [31:0]             res_ela_r;

  // output register
  logic         out_valid_r;
  logic         out_wr_r;
  logic [127:0] out_data_r;

  // divider
  div_req_t         div_req;
  div_sts_t         div_sts;
  logic [DVD_W-1:0] div_dividend;
  logic [DVD_W-1:0] div_q;
  logic [CPT_W-1:0] div_rem;

  logic [1:0]              in_mode;
  logic                    in_idle;
  logic [COUNTER_BITS-1:0] in_now;
  logic                    in_acc;
  logic                    out_free;

  logic [31:0]     per_inc;
  logic [32:0]     t_sel;
  logic [32:0]     t_m1;
  logic [CPT_W-1:0] t_clamp;
  logic [61:0]     prod;
  logic [31:0]     adj;
  logic [31:0]     lim;
  logic [31:0]     dlt;
  logic            small_gap;

  assign in_mode = in_tuser[1:0];
  assign in_idle = in_tuser[2];
  assign in_now  = in_tdata[COUNTER_BITS-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign cpt_eff = (cpt_r == '0) ? 31'd1 : cpt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpt_r       <= CPT_RESET;
      tickless_r  <= TICKLESS_RESET;
      min_delay_r <= MIN_DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CPT:       cpt_r       <= cfg_data[CPT_W-1:0];
        REG_TICKLESS:  tickless_r  <= cfg_data[0];
        REG_MIN_DELAY: min_delay_r <= cfg_data[CPT_W-1:0];
        default:       ;
      endcase
    end
  end

  // divider start and operand select
  always_comb begin
    div_req.start = 1'b0;
    div_req.wide  = 1'b0;
    div_dividend  = {32'd0, cyc_r};
    if (in_acc) begin
      case (in_mode)
        MODE_IRQ: begin
          div_req.start = tickless_r;
          div_req.wide  = 1'b1;
          div_dividend  = 64'(in_now - last_r);
        end
        MODE_TIMEOUT: begin
          div_req.start = tickless_r && !in_idle;
          div_dividend  = {32'd0, MAX_CYC - {1'b0, cpt_eff}};
        end
        MODE_ELAPSED: begin
          div_req.start = tickless_r;
          div_dividend  = {32'd0, in_now[31:0] - last_r[31:0]};
        end
        default: ;
      endcase
    end else if (state_r == S_TDIVS) begin
      div_req.start = 1'b1;
    end
  end

  tts_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (cpt_eff),
    .sts       (div_sts),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // datapath pieces, one short step per state
  always_comb begin
    per_inc = ((cpt_eff < min_delay_r) ? {cpt_eff, 1'b0} : {1'b0, cpt_eff}) - 32'd1;

    // forever maps to the largest timeout, then take one tick off and clamp
    t_sel = (t_r == 32'hFFFF_FFFF) ? {2'b00, maxt_r} : {t_r[31], t_r};
    t_m1  = t_sel - 33'd1;
    if (t_m1[32]) begin
      t_clamp = '0;
    end else if (t_m1[31:0] > {1'b0, maxt_r}) begin
      t_clamp = maxt_r;
    end else begin
      t_clamp = t_m1[CPT_W-1:0];
    end

    prod = 62'(tcl_r) * 62'(cpt_eff);

    adj = (now_r[31:0] - last_r[31:0]) + ({1'b0, cpt_eff} - 32'd1);
    lim = MAX_CYC - adj;

    dlt       = cyc_r + last_r[31:0] - now_r[31:0];
    small_gap = dlt[31] || (dlt[CPT_W-1:0] < min_delay_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            now_r     <= in_now;
            mode_r    <= in_mode;
            t_r       <= in_tdata[95:64];
            res_wr_r  <= 1'b0;
            res_cmp_r <= '0;
            res_ann_r <= '0;
            res_ela_r <= '0;
            state_r   <= S_DONE;
            case (in_mode)
              MODE_IRQ: begin
                last_r  <= in_now;
                state_r <= tickless_r ? S_DIV : S_PNXT;
              end
              MODE_TIMEOUT: begin
                if (tickless_r && !in_idle) begin
                  state_r <= S_TMAX;
                end
              end
              MODE_ELAPSED: begin
                if (tickless_r) begin
                  state_r <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            if (mode_r == MODE_IRQ) begin
              res_ann_r <= div_q[31:0];
            end else begin
              res_ela_r <= div_q[31:0];
            end
            state_r <= S_DONE;
          end
        end
        S_PNXT: begin
          res_wr_r  <= 1'b1;
          res_cmp_r <= now_r + COUNTER_BITS'(per_inc);
          res_ann_r <= 32'd1;
          state_r   <= S_DONE;
        end
        S_TMAX: begin
          if (div_sts.done) begin
            maxt_r  <= div_q[CPT_W-1:0];
            state_r <= S_TCLMP;
          end
        end
        S_TCLMP: begin
          tcl_r   <= t_clamp;
          state_r <= S_TMUL;
        end
        S_TMUL: begin
          cyc_r   <= prod[31:0];
          state_r <= S_TADJ;
        end
        S_TADJ: begin
          // saturate the target at the 31-bit limit
          cyc_r   <= (cyc_r <= lim) ? (cyc_r + adj) : MAX_CYC;
          state_r <= S_TDIVS;
        end
        S_TDIVS: begin
          state_r <= S_TDIV;
        end
        S_TDIV: begin
          if (div_sts.done) begin
            // round down to a tick boundary
            cyc_r   <= cyc_r - {1'b0, div_rem};
            state_r <= S_TSM;
          end
        end
        S_TSM: begin
          if (small_gap) begin
            cyc_r <= cyc_r + {1'b0, cpt_eff};
          end
          state_r <= S_TCMP;
        end
        S_TCMP: begin
          res_wr_r  <= 1'b1;
          res_cmp_r <= COUNTER_BITS'(cyc_r) + last_r - COUNTER_BITS'(1);
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_wr_r   <= res_wr_r;
            out_data_r <= {res_ela_r, res_ann_r, 64'(res_cmp_r)};
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // load a finished result, drop it once the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_wr_r;

  `TTS_ASSERT_IMP(a_idle_div_quiet, in_tready, !div_sts.busy)
  `TTS_ASSERT_NXT(a_one_request, in_tvalid && in_tready, !in_tready)
  `TTS_ASSERT_IMP(a_div_done_waited, div_sts.done,
                  state_r == S_DIV || state_r == S_TMAX || state_r == S_TDIV)

endmodule

FILE: sim/tick_timer_compare_scheduler_core_test.sv
// ----------------------------------------------------------------------------
// Tick timer compare scheduler core testbench
// Drives interrupt, timeout, elapsed and unused-kind requests through several
// register settings, predicts every result and checks it field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tick_timer_compare_scheduler_core_test;
  import tts_pkg::*;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam logic [7:0] REG_NONE       = 8'd3;
  localparam logic [7:0] REG_FAR        = 8'hFF;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         TAIL_CYCLES    = 150;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] now;
    logic [31:0] tmo;
    logic        idle;
  } tick_req_t;

  typedef struct packed {
    logic        wr;
    logic [63:0] cmp;
    logic [31:0] ann;
    logic [31:0] ela;
  } sched_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  tick_timer_compare_scheduler_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers and state
  logic [30:0] cfg_cpt       = CPT_RESET;
  logic        cfg_tickless  = TICKLESS_RESET;
  logic [30:0] cfg_min_delay = MIN_DELAY_RESET;
  logic [63:0] prev_announce = '0;

  tick_req_t  req_backlog[$];
  sched_res_t due_results[$];
  tick_req_t  cur_req = '0;
  logic       in_hs = 1'b0;
  logic       out_hs = 1'b0;
  int         in_gap = 0;
  int         out_stall = 0;
  bit         quiet_in = 1'b0;
  bit         quiet_out = 1'b0;
  int         errors = 0;
  int         idle_cycles = 0;
  logic [63:0] sim_count = '0;

  function automatic sched_res_t predict_sched(tick_req_t r);
    sched_res_t  res;
    logic [31:0] cpt, maxt32, cyc, adj, d;
    logic [63:0] next, dt;
    longint      t, maxt;
    res = '0;
    cpt = (cfg_cpt == '0) ? 32'd1 : {1'b0, cfg_cpt};
    case (r.mode)
      MODE_IRQ: begin
        dt = (r.now - prev_announce) / {32'd0, cpt};
        prev_announce = r.now;
        if (cfg_tickless) begin
          res.ann = dt[31:0];
        end else begin
          next = r.now + {32'd0, cpt};
          if (cpt < {1'b0, cfg_min_delay}) next = next + {32'd0, cpt};
          res.wr  = 1'b1;
          res.cmp = next - 64'd1;
          res.ann = 32'd1;
        end
      end
      MODE_TIMEOUT: begin
        if (cfg_tickless && !r.idle) begin
          maxt32 = (MAX_CYC - cpt) / cpt;
          maxt = longint'(maxt32);
          t = longint'(signed'(r.tmo));
          if (t == -1) t = maxt;
          t = t - 1;
          if (t < 0) t = 0;
          if (t > maxt) t = maxt;
          cyc = t[31:0] * cpt;
          adj = (r.now[31:0] - prev_announce[31:0]) + (cpt - 32'd1);
          if (cyc <= MAX_CYC - adj) cyc = cyc + adj;
          else cyc = MAX_CYC;
          cyc = (cyc / cpt) * cpt;
          next = {32'd0, cyc} + prev_announce - r.now;
          d = next[31:0];
          // a target behind now counts as too close as well
          if (d[31] || d < {1'b0, cfg_min_delay}) cyc = cyc + cpt;
          res.wr  = 1'b1;
          res.cmp = {32'd0, cyc} + prev_announce - 64'd1;
        end
      end
      MODE_ELAPSED: begin
        if (cfg_tickless) res.ela = (r.now[31:0] - prev_announce[31:0]) / cpt;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] random_timeout();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 20);
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      5:       return $urandom;
      6:       return $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
      7:       return -$urandom_range(2, 100);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic tick_req_t random_req();
    tick_req_t r;
    logic [63:0] step;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 36) r.mode = MODE_IRQ;
    else if (pick < 70) r.mode = MODE_TIMEOUT;
    else if (pick < 95) r.mode = MODE_ELAPSED;
    else r.mode = MODE_UNUSED;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6: step = $urandom_range(0, 50000);
      7, 8:    step = {32'd0, $urandom};
      9:       step = {$urandom, $urandom} >> $urandom_range(0, 63);
      10:      step = -$urandom_range(0, 5000);
      11:      step = {$urandom, $urandom} - sim_count;
      12:      step = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 1000) - sim_count;
      default: step = {33'd0, cfg_cpt} * $urandom_range(0, 3) + $urandom_range(0, 3) - 1;
    endcase
    sim_count = sim_count + step;
    r.now  = sim_count;
    r.tmo  = random_timeout();
    r.idle = ($urandom_range(0, 5) == 0);
    return r;
  endfunction

  task automatic push_req(logic [1:0] mode, logic [63:0] now, logic [31:0] tmo,
                          logic idle);
    tick_req_t r;
    r.mode = mode;
    r.now  = now;
    r.tmo  = tmo;
    r.idle = idle;
    req_backlog.push_back(r);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endtask

  // request side: present the next request after a random gap
  always @(negedge clk) begin : request_driver
    logic nv;
    nv = in_tvalid;
    if (rst_n) begin
      if (in_hs) begin
        nv = 1'b0;
        in_gap = quiet_in ? 0 : $urandom_range(0, 7);
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
        end else if (req_backlog.size() > 0) begin
          cur_req = req_backlog.pop_front();
          in_tdata <= {cur_req.tmo, cur_req.now};
          in_tuser <= {cur_req.idle, cur_req.mode};
          nv = 1'b1;
        end
      end
    end
    in_tvalid <= nv;
  end

  // result side: stall a random number of cycles after each result
  always @(negedge clk) begin : result_ready_driver
    if (rst_n && out_hs) out_stall = quiet_out ? 0 : $urandom_range(0, 7);
    if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  always @(posedge clk) begin : handshake_monitor
    sched_res_t got, want;
    in_hs  = rst_n && in_tvalid && in_tready;
    out_hs = rst_n && out_tvalid && out_tready;
    if (out_hs) begin
      got.wr  = out_tuser[0];
      got.cmp = out_tdata[63:0];
      got.ann = out_tdata[95:64];
      got.ela = out_tdata[127:96];
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $time, got);
      end else begin
        want = due_results.pop_front();
        check_field("compare_write", want.wr, got.wr);
        check_field("compare_value", want.cmp, got.cmp);
        check_field("announced_ticks", want.ann, got.ann);
        check_field("elapsed_ticks", want.ela, got.ela);
      end
    end
    if (in_hs) due_results.push_back(predict_sched(cur_req));
  end

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tick_timer_compare_scheduler_core_test: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CPT:       cfg_cpt       = val[30:0];
      REG_TICKLESS:  cfg_tickless  = val[0];
      REG_MIN_DELAY: cfg_min_delay = val[30:0];
      default: ;  // drop writes to unknown indexes
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold until every request is taken and every result is back
  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_tvalid || due_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(logic [31:0] cpt, logic [31:0] tickless, logic [31:0] least_gap,
                           int n, bit qin, bit qout);
    wait_drained();
    write_reg(REG_CPT, cpt);
    write_reg(REG_TICKLESS, tickless);
    write_reg(REG_MIN_DELAY, least_gap);
    if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, $urandom);
    quiet_in  = qin;
    quiet_out = qout;
    repeat (n) req_backlog.push_back(random_req());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: tick boundaries, wraps and timeout extremes
    push_req(MODE_ELAPSED, 64'd0, 32'd0, 1'b0);
    push_req(MODE_IRQ, 64'd0, 32'd0, 1'b0);
    push_req(MODE_TIMEOUT, 64'd5, 32'd0, 1'b0);
    push_req(MODE_TIMEOUT, 64'd9999, 32'd1, 1'b0);
    push_req(MODE_TIMEOUT, 64'd12345, 32'hFFFF_FFFF, 1'b0);
    push_req(MODE_TIMEOUT, 64'd777, 32'h7FFF_FFFF, 1'b0);
    push_req(MODE_TIMEOUT, 64'd778, 32'h8000_0000, 1'b0);
    push_req(MODE_TIMEOUT, 64'd800, 32'd2, 1'b1);
    push_req(MODE_IRQ, 64'd25000, 32'd0, 1'b0);
    push_req(MODE_ELAPSED, 64'd24999, 32'd0, 1'b0);
    push_req(MODE_TIMEOUT, 64'd25995, 32'd1, 1'b0);
    push_req(MODE_TIMEOUT, 64'd25000, 32'd5, 1'b0);
    push_req(MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_req(MODE_IRQ, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0);
    push_req(MODE_ELAPSED, 64'd0, 32'd0, 1'b1);
    push_req(MODE_TIMEOUT, 64'd0, 32'd3, 1'b0);
    push_req(MODE_IRQ, 64'd0, 32'd0, 1'b0);
    push_req(MODE_TIMEOUT, 64'h8000_0000_0000_0000, 32'd100, 1'b0);
    push_req(MODE_ELAPSED, 64'h0000_0001_0000_0000, 32'd0, 1'b0);
    push_req(MODE_TIMEOUT, 64'h0000_0001_0000_0000, 32'hFFFF_FFFE, 1'b0);
    wait_drained();
    write_reg(REG_FAR, 32'hFFFF_FFFF);

    run_phase(32'd10000, 32'd1, 32'd1000, 150, 1'b0, 1'b0);
    run_phase(32'd1, 32'd1, 32'd0, 100, 1'b1, 1'b0);
    // upper data bits must be masked: cycles per tick of zero acts as one
    run_phase(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 80, 1'b0, 1'b1);
    run_phase(32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 100, 1'b0, 1'b0);
    run_phase($urandom_range(1, 20000), 32'd0, $urandom_range(0, 40000), 120, 1'b1, 1'b1);
    run_phase(32'd500, 32'hFFFF_FFFE, 32'd1000, 100, 1'b0, 1'b0);
    run_phase($urandom, 32'd1, $urandom, 150, 1'b0, 1'b1);
    run_phase($urandom_range(1, 100000), 32'd1, $urandom_range(0, 100000), 250, 1'b0, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tick_timer_compare_scheduler_core_test: clean");
    end else begin
      $display("tick_timer_compare_scheduler_core_test: errors");
    end
    $finish;
  end

endmodule
